>>> hw/rtl/lav_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int SQRT_STEPS    = 32;   // one root bit per stage, 64-bit radicand

   localparam logic [1:0] ROW_LEFT = 2'd0;
   localparam logic [1:0] ROW_UP   = 2'd1;
   localparam logic [1:0] ROW_FWD  = 2'd2;

   typedef struct packed {
      logic [31:0] eye_x;
      logic [31:0] eye_y;
      logic [31:0] eye_z;
      logic [31:0] eye_w;
      logic [31:0] fwd_x;
      logic [31:0] fwd_y;
      logic [31:0] fwd_z;
      logic [31:0] fwd_w;
      logic [31:0] up_x;
      logic [31:0] up_y;
      logic [31:0] up_z;
      logic [31:0] up_w;
   } lav_req_type;

   typedef struct packed {
      logic [1:0]  row_number;
      logic [31:0] entry_x;
      logic [31:0] entry_y;
      logic [31:0] entry_z;
      logic [31:0] entry_shift;
      logic        last_row;
      logic        invalid;
   } lav_rsp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] shift;
   } lav_row_type;

   // finished matrix of one request, handed to the row serializer
   typedef struct packed {
      logic                 bad;
      logic [2:0][127:0]    row;
   } lav_rows_type;

endpackage
`default_nettype wire

>>> hw/rtl/look_at_view_matrix_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Look-at view matrix: left, true up and negated forward rows with translation.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one request: eye point, forward and up vectors (with w).
//  - rsp_* returns the rows of the view matrix, rows 0, 1, 2 in order, the
//    last flagged by last_row. A rejected request (bad w or a zero-length
//    vector) returns a single row with invalid and last_row set.
//  - From request accept to first row (Q15.16 by default) a request passes
//    input, squares, sum, 32 root stages, FRAC_BITS+2 divider stages, five
//    cross/dot stages and the output register.
//  - Throughput: every stage moves each cycle unless the pipeline stalls, so
//    it can take a request per cycle; the output register sends one row per
//    cycle while the receiver does not stall, three rows per request (one for rejected requests).
//  - The pipeline moves as one: while D5 holds a matrix that the busy
//    output register cannot load yet, all stages hold and req_stall rises.
//  - Synchronous reset clears the valid bits of every stage and the
//    output register; nothing is lost or repeated across stalls.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit import lav_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire lav_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output lav_rsp_type      rsp_data
);

   localparam int EW = FRAC_BITS + 3;   // width of unit vectors and rows
   localparam int PW = EW + 32;         // row times eye product
   localparam int QB = FRAC_BITS + 1;
   localparam logic signed [31:0] ONE  = 32'(1) << FRAC_BITS;
   localparam logic [63:0]        HALF = 64'(1) << (FRAC_BITS - 1);
   localparam logic signed [63:0] SMAX = 64'sd2147483647;
   localparam logic signed [63:0] SMIN = -64'sd2147483648;

   typedef struct packed {
      logic             bad;
      logic [2:0][31:0] eye;
      logic [2:0][31:0] fmag;
      logic [2:0][31:0] umag;
      logic [2:0]       fneg;
      logic [2:0]       uneg;
   } root_carry_type;

   typedef struct packed {
      logic             bad;
      logic [2:0][31:0] eye;
      logic [2:0]       fneg;
      logic [2:0]       uneg;
   } div_carry_type;

   // round to nearest, ties away from zero, then drop the fraction
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + HALF) >> FRAC_BITS;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   // whole pipeline advances together
   logic adv;
   logic ser_ready;

   // ---- stage A: request register
   logic        a_valid_ff;
   lav_req_type a_data_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (adv) a_valid_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) a_data_ff <= req_data;
   end

   // ---- stage B: magnitudes, squares, w checks
   logic             b_valid_ff;
   logic             b_bad_ff;
   logic [2:0][31:0] b_eye_ff, b_fmag_ff, b_umag_ff;
   logic [2:0]       b_fneg_ff, b_uneg_ff;
   logic [63:0]      b_fsq_ff [3];
   logic [63:0]      b_usq_ff [3];
   logic [2:0][31:0] a_f, a_u, a_fm, a_um;

   assign a_f = {a_data_ff.fwd_z, a_data_ff.fwd_y, a_data_ff.fwd_x};
   assign a_u = {a_data_ff.up_z, a_data_ff.up_y, a_data_ff.up_x};
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_fm[i] = mag32(a_f[i]);
         a_um[i] = mag32(a_u[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (adv) b_valid_ff <= a_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_bad_ff  <= ($signed(a_data_ff.eye_w) < ONE) || ($signed(a_data_ff.fwd_w) > 0)
                   || ($signed(a_data_ff.up_w) > 0);
         b_eye_ff  <= {a_data_ff.eye_z, a_data_ff.eye_y, a_data_ff.eye_x};
         b_fmag_ff <= a_fm;
         b_umag_ff <= a_um;
         for (int i = 0; i < 3; i++) begin
            b_fneg_ff[i] <= a_f[i][31];
            b_uneg_ff[i] <= a_u[i][31];
            b_fsq_ff[i]  <= 64'(a_fm[i]) * 64'(a_fm[i]);
            b_usq_ff[i]  <= 64'(a_um[i]) * 64'(a_um[i]);
         end
      end
   end

   // ---- stage C: squared lengths, zero-length check
   logic           c_valid_ff;
   logic [63:0]    c_fs_ff, c_us_ff;
   root_carry_type c_carry_ff;
   logic [63:0]    b_fs, b_us;

   assign b_fs = b_fsq_ff[0] + b_fsq_ff[1] + b_fsq_ff[2];
   assign b_us = b_usq_ff[0] + b_usq_ff[1] + b_usq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (adv) c_valid_ff <= b_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_fs_ff         <= b_fs;
         c_us_ff         <= b_us;
         c_carry_ff.bad  <= b_bad_ff || (b_fs == 64'd0) || (b_us == 64'd0);
         c_carry_ff.eye  <= b_eye_ff;
         c_carry_ff.fmag <= b_fmag_ff;
         c_carry_ff.umag <= b_umag_ff;
         c_carry_ff.fneg <= b_fneg_ff;
         c_carry_ff.uneg <= b_uneg_ff;
      end
   end

   // ---- square roots
   logic [31:0]    f_len, u_len;
   logic           r_valid;
   root_carry_type r_carry;

   lav_sqrt_pipe u_sqrt_fwd (.clock(clock), .en(adv), .sq_in(c_fs_ff), .root_out(f_len));
   lav_sqrt_pipe u_sqrt_up  (.clock(clock), .en(adv), .sq_in(c_us_ff), .root_out(u_len));

   lav_delay_line #(.WIDTH($bits(root_carry_type)), .DEPTH(SQRT_STEPS)) u_root_line (
      .clock(clock), .reset(reset), .en(adv),
      .valid_in(c_valid_ff), .data_in(c_carry_ff),
      .valid_out(r_valid), .data_out(r_carry)
   );

   // ---- normalizing divisions, three per vector
   logic [FRAC_BITS:0] f_quo [3];
   logic [FRAC_BITS:0] u_quo [3];
   logic               v_valid;
   div_carry_type      r_dcarry, v_carry;

   for (genvar i = 0; i < 3; i++) begin : g_div
      lav_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_fwd (
         .clock(clock), .en(adv), .mag_in(r_carry.fmag[i]), .len_in(f_len),
         .quo_out(f_quo[i])
      );
      lav_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_up (
         .clock(clock), .en(adv), .mag_in(r_carry.umag[i]), .len_in(u_len),
         .quo_out(u_quo[i])
      );
   end

   assign r_dcarry.bad  = r_carry.bad;
   assign r_dcarry.eye  = r_carry.eye;
   assign r_dcarry.fneg = r_carry.fneg;
   assign r_dcarry.uneg = r_carry.uneg;

   lav_delay_line #(.WIDTH($bits(div_carry_type)), .DEPTH(QB + 1)) u_div_line (
      .clock(clock), .reset(reset), .en(adv),
      .valid_in(r_valid), .data_in(r_dcarry),
      .valid_out(v_valid), .data_out(v_carry)
   );

   // signed unit vectors
   logic signed [EW-1:0] fn_c [3];
   logic signed [EW-1:0] un_c [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fn_c[i] = v_carry.fneg[i] ? -$signed(EW'(f_quo[i])) : $signed(EW'(f_quo[i]));
         un_c[i] = v_carry.uneg[i] ? -$signed(EW'(u_quo[i])) : $signed(EW'(u_quo[i]));
      end
   end

   // ---- D1: fwd x up products
   logic                   d1_valid_ff, d1_bad_ff;
   logic [2:0][31:0]       d1_eye_ff;
   logic signed [EW-1:0]   d1_fn_ff [3];
   logic signed [2*EW-1:0] d1_p_ff  [6];

   always_ff @(posedge clock) begin
      if (reset) d1_valid_ff <= 1'b0;
      else if (adv) d1_valid_ff <= v_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_bad_ff  <= v_carry.bad;
         d1_eye_ff  <= v_carry.eye;
         d1_fn_ff   <= fn_c;
         d1_p_ff[0] <= fn_c[1] * un_c[2];
         d1_p_ff[1] <= fn_c[2] * un_c[1];
         d1_p_ff[2] <= fn_c[2] * un_c[0];
         d1_p_ff[3] <= fn_c[0] * un_c[2];
         d1_p_ff[4] <= fn_c[0] * un_c[1];
         d1_p_ff[5] <= fn_c[1] * un_c[0];
      end
   end

   // ---- D2: left row
   logic                 d2_valid_ff, d2_bad_ff;
   logic [2:0][31:0]     d2_eye_ff;
   logic signed [EW-1:0] d2_fn_ff   [3];
   logic signed [EW-1:0] d2_left_ff [3];

   always_ff @(posedge clock) begin
      if (reset) d2_valid_ff <= 1'b0;
      else if (adv) d2_valid_ff <= d1_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d2_bad_ff <= d1_bad_ff;
         d2_eye_ff <= d1_eye_ff;
         d2_fn_ff  <= d1_fn_ff;
         for (int i = 0; i < 3; i++) begin
            d2_left_ff[i] <= EW'(round_shift(64'(d1_p_ff[2*i]) - 64'(d1_p_ff[2*i+1])));
         end
      end
   end

   // ---- D3: left x fwd products
   logic                   d3_valid_ff, d3_bad_ff;
   logic [2:0][31:0]       d3_eye_ff;
   logic signed [EW-1:0]   d3_fn_ff   [3];
   logic signed [EW-1:0]   d3_left_ff [3];
   logic signed [2*EW-1:0] d3_p_ff    [6];

   always_ff @(posedge clock) begin
      if (reset) d3_valid_ff <= 1'b0;
      else if (adv) d3_valid_ff <= d2_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d3_bad_ff  <= d2_bad_ff;
         d3_eye_ff  <= d2_eye_ff;
         d3_fn_ff   <= d2_fn_ff;
         d3_left_ff <= d2_left_ff;
         d3_p_ff[0] <= d2_left_ff[1] * d2_fn_ff[2];
         d3_p_ff[1] <= d2_left_ff[2] * d2_fn_ff[1];
         d3_p_ff[2] <= d2_left_ff[2] * d2_fn_ff[0];
         d3_p_ff[3] <= d2_left_ff[0] * d2_fn_ff[2];
         d3_p_ff[4] <= d2_left_ff[0] * d2_fn_ff[1];
         d3_p_ff[5] <= d2_left_ff[1] * d2_fn_ff[0];
      end
   end

   // ---- D4: all three rows
   logic                 d4_valid_ff, d4_bad_ff;
   logic [2:0][31:0]     d4_eye_ff;
   logic signed [EW-1:0] d4_row_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) d4_valid_ff <= 1'b0;
      else if (adv) d4_valid_ff <= d3_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d4_bad_ff <= d3_bad_ff;
         d4_eye_ff <= d3_eye_ff;
         for (int i = 0; i < 3; i++) begin
            d4_row_ff[0][i] <= d3_left_ff[i];
            d4_row_ff[1][i] <= EW'(round_shift(64'(d3_p_ff[2*i]) - 64'(d3_p_ff[2*i+1])));
            d4_row_ff[2][i] <= -d3_fn_ff[i];
         end
      end
   end

   // ---- D5: row times eye products
   logic                 d5_valid_ff, d5_bad_ff;
   logic signed [EW-1:0] d5_row_ff [3][3];
   logic signed [PW-1:0] d5_p_ff   [3][3];

   always_ff @(posedge clock) begin
      if (reset) d5_valid_ff <= 1'b0;
      else if (adv) d5_valid_ff <= d4_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d5_bad_ff <= d4_bad_ff;
         d5_row_ff <= d4_row_ff;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               d5_p_ff[k][i] <= d4_row_ff[k][i] * $signed(d4_eye_ff[i]);
            end
         end
      end
   end

   // ---- D6: translation, rounded, negated and saturated, into the output register
   lav_rows_type     fin_rows;
   logic signed [63:0] dsum [3];
   logic signed [63:0] dneg [3];
   lav_row_type      fin_row [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dsum[k] = round_shift(64'(d5_p_ff[k][0]) + 64'(d5_p_ff[k][1]) + 64'(d5_p_ff[k][2]));
         dneg[k] = -dsum[k];
         fin_row[k].x = 32'(d5_row_ff[k][0]);
         fin_row[k].y = 32'(d5_row_ff[k][1]);
         fin_row[k].z = 32'(d5_row_ff[k][2]);
         if (dneg[k] > SMAX) fin_row[k].shift = SMAX[31:0];
         else if (dneg[k] < SMIN) fin_row[k].shift = SMIN[31:0];
         else fin_row[k].shift = dneg[k][31:0];
         fin_rows.row[k] = fin_row[k];
      end
      fin_rows.bad = d5_bad_ff;
   end

   lav_row_serializer u_ser (
      .clock(clock), .reset(reset),
      .load_valid(d5_valid_ff), .load_rows(fin_rows), .load_ready(ser_ready),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   assign adv       = !d5_valid_ff || ser_ready;
   assign req_stall = !adv;

   // ---- checks
   a_invalid_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.invalid |-> rsp_data.last_row)
      else $error("rejected request not flagged as last row");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.invalid |-> rsp_data.row_number != 2'd3)
      else $error("row number out of range");

   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_row |=> rsp_valid)
      else $error("matrix rows broken off before last row");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      d5_valid_ff && req_stall |=> d5_valid_ff && $stable(d5_bad_ff))
      else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

>>> hw/rtl/lav_delay_line.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lav_delay_line
// Enabled shift line that carries side data and its valid bit past a unit.
// ----------------------------------------------------------------------------
module lav_delay_line #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             valid_in,
   input  wire logic [WIDTH-1:0] data_in,
   output logic                  valid_out,
   output logic [WIDTH-1:0]      data_out
);

   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] data_ff  [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= valid_in;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= data_in;
         for (int i = 1; i < DEPTH; i++) data_ff[i] <= data_ff[i-1];
      end
   end

   assign valid_out = valid_ff[DEPTH-1];
   assign data_out  = data_ff[DEPTH-1];

endmodule
`default_nettype wire

>>> hw/rtl/lav_sqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lav_sqrt_pipe
// Pipelined integer square root, floor(sqrt(s)), one result bit per stage.
// ----------------------------------------------------------------------------
module lav_sqrt_pipe import lav_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] sq_in,
   output logic [31:0]      root_out
);

   logic [63:0] s_st [SQRT_STEPS+1];
   logic [63:0] r_st [SQRT_STEPS+1];
   logic [63:0] s_in [SQRT_STEPS];
   logic [63:0] r_in [SQRT_STEPS];
   logic [63:0] s_ff [SQRT_STEPS];
   logic [63:0] r_ff [SQRT_STEPS];

   assign s_st[0] = sq_in;
   assign r_st[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
      logic [63:0] trial;
      always_comb begin
         trial = r_st[k] + BIT;
         if (s_st[k] >= trial) begin
            s_in[k] = s_st[k] - trial;
            r_in[k] = (r_st[k] >> 1) + BIT;
         end else begin
            s_in[k] = s_st[k];
            r_in[k] = r_st[k] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            s_ff[k] <= s_in[k];
            r_ff[k] <= r_in[k];
         end
      end
      assign s_st[k+1] = s_ff[k];
      assign r_st[k+1] = r_ff[k];
   end

   assign root_out = r_st[SQRT_STEPS][31:0];

endmodule
`default_nettype wire

>>> hw/rtl/lav_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lav_div_pipe
// Pipelined restoring divider: round(mag * 2^F / len), one quotient bit a stage.
// ----------------------------------------------------------------------------
module lav_div_pipe import lav_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [31:0]      mag_in,
   input  wire logic [31:0]      len_in,
   output logic [FRAC_BITS:0]    quo_out
);

   localparam int QB = FRAC_BITS + 1;   // quotient never reaches 2^QB
   localparam int NW = 32 + QB + 1;     // numerator width
   localparam int RW = NW - QB;         // partial remainder width

   logic [NW-1:0] num;
   logic [RW-1:0] rem_st [QB+1];
   logic [QB-1:0] lo_st  [QB+1];
   logic [QB-1:0] q_st   [QB+1];
   logic [32:0]   d_st   [QB+1];
   logic [RW-1:0] rem_ff [QB+1];
   logic [QB-1:0] lo_ff  [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [32:0]   d_ff   [QB+1];

   // numerator (mag << (F+1)) + len, divisor 2*len
   assign num = (NW'(mag_in) << QB) + NW'(len_in);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num[NW-1:QB];
         lo_ff[0]  <= num[QB-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= {len_in, 1'b0};
      end
   end

   for (genvar j = 0; j <= QB; j++) begin : g_tap
      assign rem_st[j] = rem_ff[j];
      assign lo_st[j]  = lo_ff[j];
      assign q_st[j]   = q_ff[j];
      assign d_st[j]   = d_ff[j];
   end

   for (genvar j = 0; j < QB; j++) begin : g_step
      logic [RW:0]   trial;
      logic [RW-1:0] rem_in;
      logic          qbit;
      always_comb begin
         trial = {rem_st[j], lo_st[j][QB-1]};
         if (trial >= (RW+1)'(d_st[j])) begin
            rem_in = RW'(trial - (RW+1)'(d_st[j]));
            qbit   = 1'b1;
         end else begin
            rem_in = RW'(trial);
            qbit   = 1'b0;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= rem_in;
            lo_ff[j+1]  <= lo_st[j] << 1;
            q_ff[j+1]   <= {q_st[j][QB-2:0], qbit};
            d_ff[j+1]   <= d_st[j];
         end
      end
   end

   assign quo_out = q_st[QB];

endmodule
`default_nettype wire

>>> hw/rtl/lav_row_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lav_row_serializer
// Output register: sends the rows of one finished matrix, or one invalid row if rejected.
// ----------------------------------------------------------------------------
module lav_row_serializer import lav_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load_valid,
   input  wire lav_rows_type load_rows,
   output logic              load_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output lav_rsp_type       rsp_data
);

   logic         busy_ff;
   logic [1:0]   cnt_ff;
   lav_rows_type rows_ff;
   logic         take;
   logic         last;
   lav_row_type  cur;

   assign take       = busy_ff && !rsp_stall;
   assign last       = rows_ff.bad || (cnt_ff == ROW_FWD);
   assign load_ready = !busy_ff || (take && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= ROW_LEFT;
      end else if (load_ready && load_valid) begin
         busy_ff <= 1'b1;
         cnt_ff  <= ROW_LEFT;
      end else if (take && last) begin
         busy_ff <= 1'b0;
      end else if (take) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) rows_ff <= load_rows;
   end

   always_comb begin
      case (cnt_ff)
         ROW_LEFT: cur = rows_ff.row[0];
         ROW_UP:   cur = rows_ff.row[1];
         ROW_FWD:  cur = rows_ff.row[2];
         default:  cur = '0;
      endcase
   end

   assign rsp_valid = busy_ff;

   always_comb begin
      if (rows_ff.bad) begin
         rsp_data          = '0;
         rsp_data.last_row = 1'b1;
         rsp_data.invalid  = 1'b1;
      end else begin
         rsp_data.row_number  = cnt_ff;
         rsp_data.entry_x     = cur.x;
         rsp_data.entry_y     = cur.y;
         rsp_data.entry_z     = cur.z;
         rsp_data.entry_shift = cur.shift;
         rsp_data.last_row    = last;
         rsp_data.invalid     = 1'b0;
      end
   end

endmodule
`default_nettype wire
